[design/rpn_pkg.sv]
package rpn_pkg;

   localparam int unsigned DEFAULT_STACK_DEPTH = 32;
   localparam int unsigned DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_POW    = 3'd5,
      OP_FINISH = 3'd6,
      OP_NONE   = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_UNDER   = 3'd2,
      ST_OVER    = 3'd3,
      ST_DIVZERO = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
      logic [2:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_RIGHT,
      S_RD_LEFT,
      S_LATCH,
      S_EXEC,
      S_MUL_WAIT,
      S_POW_STEP,
      S_POW_WAIT,
      S_DIV_STEP,
      S_WRITE,
      S_DRAIN_RD,
      S_DRAIN_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       push;
      logic       rd_right;
      logic       rd_left;
      logic       latch_right;
      logic       latch_left;
      logic       exec_init;
      logic       mul_step;
      logic       pow_step;
      logic       div_step;
      logic       write_res;
      logic       drain_out;
      logic       empty_out;
      logic       clear;
      logic [2:0] op;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic lt_two;
      logic empty;
      logic div_zero;
      logic pow_done;
      logic div_done;
      logic last_drain;
   } stat_type;

endpackage

[design/rpn_ram.sv]
module rpn_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/rpn_datapath.sv]
module rpn_datapath import rpn_pkg::*; #(
   parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  req_type  req,
   output stat_type stat,
   output rsp_type  rsp_data,
   output logic     rsp_strobe
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

   logic [PW-1:0] sp_ff, sp_in;
   logic [2:0]    err_ff, err_in;
   logic [31:0]   left_ff, left_in, right_ff, right_in;
   logic [31:0]   acc_ff, acc_in, base_ff, base_in, expo_ff, expo_in;
   logic [31:0]   rem_ff, rem_in, quo_ff, quo_in, dvs_ff;
   logic [5:0]    cnt_ff, cnt_in;
   logic [31:0]   res_ff, res_in;
   logic [31:0]   prod_ff;
   logic          prod_sel_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;
   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;
   logic [32:0]   trial;
   logic [31:0]   a_mag, b_mag, q_adj;
   logic [PW-1:0] top_idx;

   rpn_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign top_idx = sp_ff - PW'(1);

   always_comb begin
      rd_addr = top_idx[AW-1:0];
      if (cmd.rd_left) begin
         rd_addr = AW'(sp_ff - PW'(2));
      end
      wr_en   = 1'b0;
      wr_addr = sp_ff[AW-1:0];
      wr_data = req.operand;
      if (cmd.push && !stat.full) begin
         wr_en = 1'b1;
      end
      if (cmd.write_res) begin
         wr_en   = 1'b1;
         wr_addr = AW'(sp_ff - PW'(2));
         wr_data = res_ff;
      end
   end

   assign a_mag = left_ff[31] ? (32'd0 - left_ff) : left_ff;
   assign b_mag = right_ff[31] ? (32'd0 - right_ff) : right_ff;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
   assign q_adj = (left_ff[31] ^ right_ff[31]) ?
                  ((rem_ff != 32'd0) ? (32'd0 - quo_ff - 32'd1) : (32'd0 - quo_ff)) : quo_ff;

   always_comb begin
      sp_in     = sp_ff;
      err_in    = err_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      expo_in   = expo_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      if (cmd.push) begin
         if (stat.full) begin
            if (err_ff == ST_OK) err_in = ST_OVER;
         end else begin
            sp_in = sp_ff + PW'(1);
         end
      end
      if (cmd.op != OP_PUSH && cmd.exec_init == 1'b0 && cmd.rd_right && stat.lt_two) begin
         if (err_ff == ST_OK) err_in = ST_UNDER;
      end
      if (cmd.latch_right) right_in = rd_data;
      if (cmd.latch_left)  left_in  = rd_data;
      if (cmd.exec_init) begin
         unique case (opcode_type'(cmd.op))
            OP_ADD: res_in = left_ff + right_ff;
            OP_SUB: res_in = left_ff - right_ff;
            OP_DIV: begin
               if (right_ff == 32'd0) begin
                  if (err_ff == ST_OK) err_in = ST_DIVZERO;
               end
               rem_in = 32'd0;
               quo_in = a_mag;
               cnt_in = 6'd0;
            end
            OP_POW: begin
               acc_in  = 32'd1;
               base_in = left_ff;
               expo_in = right_ff[31] ? 32'd0 : right_ff;
               cnt_in  = 6'd0;
            end
            default: ;
         endcase
      end
      if (cmd.mul_step) res_in = prod_ff;
      if (cmd.pow_step) begin
         expo_in = {1'b0, expo_ff[31:1]};
         cnt_in  = cnt_ff + 6'd1;
      end
      if (cmd.pow_step == 1'b0 && prod_sel_ff) begin
         acc_in = prod_ff;
      end
      if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
      end
      if (cmd.write_res) begin
         sp_in = sp_ff - PW'(1);
      end
      if (cmd.drain_out) begin
         strobe_in     = 1'b1;
         rsp_in.value  = rd_data;
         rsp_in.last   = (sp_ff == PW'(1));
         rsp_in.status = err_ff;
         sp_in         = sp_ff - PW'(1);
      end
      if (cmd.empty_out) begin
         strobe_in     = 1'b1;
         rsp_in.value  = 32'sd0;
         rsp_in.last   = 1'b1;
         rsp_in.status = (err_ff != ST_OK) ? err_ff : ST_EMPTY;
      end
      if (cmd.clear) begin
         sp_in  = '0;
         err_in = ST_OK;
      end
   end

   // power: alternating multiply cycles, one step per exponent bit
   logic [31:0] mul_a, mul_b;
   always_comb begin
      mul_a = left_ff;
      mul_b = right_ff;
      if (cmd.pow_step) begin
         mul_a = acc_ff;
         mul_b = base_ff;
      end
   end

   logic [31:0] sq_ff;
   always_ff @(posedge clock) begin
      prod_ff     <= 32'(mul_a * mul_b);
      sq_ff       <= 32'(base_ff * base_ff);
      prod_sel_ff <= cmd.pow_step & expo_ff[0];
      if (cmd.pow_step == 1'b0 && cnt_ff != 6'd0 && cmd.op == OP_POW && !cmd.write_res
          && !cmd.exec_init) begin
         base_ff <= sq_ff;
      end else begin
         base_ff <= base_in;
      end
      if (cmd.exec_init) dvs_ff <= b_mag;
      left_ff  <= left_in;
      right_ff <= right_in;
      acc_ff   <= acc_in;
      expo_ff  <= expo_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rsp_ff   <= rsp_in;
      if (cmd.op == OP_DIV && cmd.exec_init == 1'b0 && stat.div_done && !cmd.div_step
          && !cmd.write_res) begin
         res_ff <= q_adj;
      end else if (cmd.op == OP_POW && stat.pow_done && !cmd.pow_step && !cmd.write_res) begin
         res_ff <= acc_in;
      end else begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff     <= '0;
         err_ff    <= ST_OK;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         sp_ff     <= sp_in;
         err_ff    <= err_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   assign stat.full       = (sp_ff >= PW'(STACK_DEPTH));
   assign stat.lt_two     = (sp_ff < PW'(2));
   assign stat.empty      = (sp_ff == '0);
   assign stat.div_zero   = (right_ff == 32'd0);
   assign stat.pow_done   = (expo_ff == 32'd0);
   assign stat.div_done   = (cnt_ff == 6'd32);
   assign stat.last_drain = (sp_ff == PW'(1));

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

[design/rpn_control.sv]
module rpn_control import rpn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type state_ff, state_in;
   logic [2:0] op_ff, op_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req.opcode;
               unique case (opcode_type'(req.opcode))
                  OP_PUSH, OP_NONE: state_in = S_IDLE;
                  OP_FINISH: state_in = stat.empty ? S_DRAIN_OUT : S_DRAIN_RD;
                  default: state_in = stat.lt_two ? S_IDLE : S_RD_RIGHT;
               endcase
            end
         end
         S_RD_RIGHT: state_in = S_RD_LEFT;
         S_RD_LEFT:  state_in = S_LATCH;
         S_LATCH:    state_in = S_EXEC;
         S_EXEC: begin
            unique case (opcode_type'(op_ff))
               OP_MUL: state_in = S_MUL_WAIT;
               OP_DIV: state_in = stat.div_zero ? S_IDLE : S_DIV_STEP;
               OP_POW: state_in = S_POW_STEP;
               default: state_in = S_WRITE;
            endcase
         end
         S_MUL_WAIT: state_in = S_WRITE;
         S_POW_STEP: state_in = S_POW_WAIT;
         S_POW_WAIT: state_in = stat.pow_done ? S_WRITE : S_POW_STEP;
         S_DIV_STEP: state_in = stat.div_done ? S_WRITE : S_DIV_STEP;
         S_WRITE:    state_in = S_IDLE;
         S_DRAIN_RD: state_in = S_DRAIN_OUT;
         S_DRAIN_OUT: begin
            if (stat.empty || stat.last_drain) state_in = S_IDLE;
            else state_in = S_DRAIN_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.op        = op_ff;
      busy          = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.op = req.opcode;
            if (start) begin
               cmd.push = (req.opcode == OP_PUSH);
               if (req.opcode != OP_PUSH && req.opcode != OP_FINISH && req.opcode != OP_NONE)
                  cmd.rd_right = 1'b1;
            end
         end
         S_RD_RIGHT:  cmd.rd_left = 1'b1;
         S_RD_LEFT:   cmd.latch_left = 1'b1;
         S_LATCH:     cmd.latch_right = 1'b1;
         S_EXEC:      cmd.exec_init = 1'b1;
         S_MUL_WAIT:  cmd.mul_step = 1'b1;
         S_POW_STEP:  cmd.pow_step = 1'b1;
         S_POW_WAIT:  ;
         S_DIV_STEP:  cmd.div_step = !stat.div_done;
         S_WRITE:     cmd.write_res = 1'b1;
         S_DRAIN_RD:  ;
         S_DRAIN_OUT: begin
            if (stat.empty) begin
               cmd.empty_out = 1'b1;
               cmd.clear     = 1'b1;
            end else begin
               cmd.drain_out = 1'b1;
               cmd.clear     = stat.last_drain;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_PUSH;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> (state_ff == S_IDLE))
      else $error("write not followed by idle");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.opcode == OP_PUSH) |=> (state_ff == S_IDLE))
      else $error("push left idle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STEP && !stat.div_done) |=> (state_ff == S_DIV_STEP))
      else $error("divide left early");

endmodule

[design/rpn_stack_calculator.sv]
// push writes the stack from idle; add/sub read right, read left, latch, execute, write; multiply
// adds a wait, power a step and a wait per exponent bit on the shared multiplier (one step at least),
// divide a step per quotient bit; finish reads then outputs each entry through the single ram read port
// sequential: one item at a time, busy high until the item completes
// reset (synchronous, active high) empties the stack and clears the error status
// the receiver cannot stall: each result is shown for one cycle with rsp_strobe
module rpn_stack_calculator import rpn_pkg::*; #(
   parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output rsp_type rsp_data,
   output logic    rsp_strobe
);

   cmd_type  cmd;
   stat_type stat;

   rpn_control u_control (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req  (req_data),
      .stat (stat),
      .cmd  (cmd),
      .busy (busy)
   );

   rpn_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_data),
      .stat      (stat),
      .rsp_data  (rsp_data),
      .rsp_strobe(rsp_strobe)
   );

endmodule
